@@ rtl/core/hxb_pkg.sv @@
// ----------------------------------------------------------------------------
// hxb_pkg
// Shared types, constants and the hex digit decoder for the hex text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hxb_pkg;

   localparam int unsigned CountWidth = 16;
   localparam int unsigned CharWidth  = 8;
   localparam int unsigned NibWidth   = 4;
   localparam int unsigned CsrWidth   = 32;
   localparam int unsigned AddrWidth  = 2;

   localparam logic [AddrWidth-1:0]  AddrOutCapacity  = 2'd0;
   localparam logic [CountWidth-1:0] CapacityReset    = 16'hFFFF;

   localparam logic [CharWidth-1:0] ChSpace = 8'h20;
   localparam logic [CharWidth-1:0] ChColon = 8'h3A;
   localparam logic [CharWidth-1:0] ChZero  = 8'h30;
   localparam logic [CharWidth-1:0] ChNine  = 8'h39;
   localparam logic [CharWidth-1:0] ChLowA  = 8'h61;
   localparam logic [CharWidth-1:0] ChLowF  = 8'h66;
   localparam logic [CharWidth-1:0] ChUpA   = 8'h41;
   localparam logic [CharWidth-1:0] ChUpF   = 8'h46;
   localparam logic [CharWidth-1:0] DigitTen = 8'd10;

   // per-string parse state
   typedef struct packed {
      logic                  need_low;
      logic [NibWidth-1:0]   high_nibble;
      logic [CountWidth-1:0] produced;
      logic                  in_trailer;
      logic                  failed;
   } hxb_state_type;

   // one result word
   typedef struct packed {
      logic                  valid;
      logic                  byte_valid;
      logic [CharWidth-1:0]  data_byte;
      logic                  done_res;
      logic                  status;
      logic [CountWidth-1:0] byte_count;
   } hxb_res_type;

   // {is_digit, value}
   function automatic logic [NibWidth:0] hex_digit(input logic [CharWidth-1:0] ch);
      logic [CharWidth-1:0] v;
      logic                 ok;
      v  = '0;
      ok = 1'b0;
      if (ch inside {[ChZero:ChNine]}) begin
         v  = ch - ChZero;
         ok = 1'b1;
      end else if (ch inside {[ChLowA:ChLowF]}) begin
         v  = ch - ChLowA + DigitTen;
         ok = 1'b1;
      end else if (ch inside {[ChUpA:ChUpF]}) begin
         v  = ch - ChUpA + DigitTen;
         ok = 1'b1;
      end
      return {ok, v[NibWidth-1:0]};
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/hxb_step.sv @@
// ----------------------------------------------------------------------------
// hxb_step
// Per-character decision: next parse state and the result word, if any.
// ----------------------------------------------------------------------------
`default_nettype none

module hxb_step (
   input  wire logic [hxb_pkg::CharWidth-1:0]  character,
   input  wire logic                           has_char,
   input  wire logic                           last,
   input  wire logic [hxb_pkg::CountWidth-1:0] out_capacity,
   input  wire hxb_pkg::hxb_state_type         state_cur,
   output hxb_pkg::hxb_state_type              state_nxt,
   output hxb_pkg::hxb_res_type                result
);
   import hxb_pkg::*;

   logic [NibWidth:0]    dig;
   logic                 sep;
   logic                 emit;
   logic [CharWidth-1:0] byte_val;
   hxb_state_type        n;

   always_comb begin
      dig      = hex_digit(character);
      sep      = character inside {ChSpace, ChColon};
      n        = state_cur;
      emit     = 1'b0;
      byte_val = '0;

      if (has_char && !state_cur.failed) begin
         if (state_cur.in_trailer || (state_cur.produced >= out_capacity)) begin
            n.in_trailer = 1'b1;
            if (!sep) n.failed = 1'b1;
         end else if (dig[NibWidth]) begin
            if (state_cur.need_low) begin
               byte_val   = {state_cur.high_nibble, dig[NibWidth-1:0]};
               emit       = 1'b1;
               n.produced = state_cur.produced + 1'b1;
               n.need_low = 1'b0;
            end else begin
               n.high_nibble = dig[NibWidth-1:0];
               n.need_low    = 1'b1;
            end
         end else if (sep) begin
            if (state_cur.need_low) n.failed = 1'b1;
         end else begin
            n.failed = 1'b1;
         end
      end

      // end of string: a lone nibble stands as a byte only when nothing came before
      if (last && !n.failed && n.need_low) begin
         if ((n.produced == '0) && (out_capacity != '0)) begin
            byte_val   = {{(CharWidth-NibWidth){1'b0}}, n.high_nibble};
            emit       = 1'b1;
            n.produced = {{(CountWidth-1){1'b0}}, 1'b1};
            n.need_low = 1'b0;
         end else begin
            n.failed = 1'b1;
         end
      end

      result.valid      = emit || last;
      result.byte_valid = emit;
      result.data_byte  = emit ? byte_val : '0;
      result.done_res   = last;
      result.status     = last ? n.failed : 1'b0;
      result.byte_count = last ? n.produced : '0;

      state_nxt = last ? '0 : n;
   end

endmodule

`default_nettype wire

@@ rtl/core/hex_text_to_bytes.sv @@
// ----------------------------------------------------------------------------
// hex_text_to_bytes
// Hex text parser: pairs hex characters into bytes, checks separators and
// capacity, and closes each string with a status and byte count word.
// ----------------------------------------------------------------------------
// Path: an accepted request word is held in the input register, then in the result register, as its response word.
// Throughput: one request word per cycle; the input register and the result
//   register form a two-stage pipeline held only by rsp_stall.
// Reset: synchronous, active high; clears the pipeline valids and the parse
//   state, and sets out_capacity to 65535. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_text_to_bytes (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic [hxb_pkg::CharWidth-1:0]  req_character,
   input  wire logic                           req_has_char,
   input  wire logic                           req_last,
   // response channel
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic                           rsp_byte_valid,
   output      logic [hxb_pkg::CharWidth-1:0]  rsp_data_byte,
   output      logic                           rsp_done_res,
   output      logic                           rsp_status,
   output      logic [hxb_pkg::CountWidth-1:0] rsp_byte_count,
   // register port
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [hxb_pkg::AddrWidth-1:0]  paddr,
   input  wire logic [hxb_pkg::CsrWidth-1:0]   pwdata,
   output      logic [hxb_pkg::CsrWidth-1:0]   prdata,
   output      logic                           pready
);
   import hxb_pkg::*;

   // ---------------------------------------------------------------------
   // Register port: one register, out_capacity, at byte address 0.
   // Writes land on the access phase; reads return the live value.
   // ---------------------------------------------------------------------
   logic [CountWidth-1:0] capacity_ff;
   logic [CountWidth-1:0] capacity_in;
   logic                  csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write && (paddr == AddrOutCapacity)) begin
         capacity_in = pwdata[CountWidth-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == AddrOutCapacity) begin
         prdata = {{(CsrWidth-CountWidth){1'b0}}, capacity_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CapacityReset;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control.
   // out_free: the result register can take a word this cycle, either
   // because it is empty or because its word leaves now.
   // s1_take: the input register can take a word, either because it is
   // empty or because its word advances into the result stage now.
   // ---------------------------------------------------------------------
   logic out_free;
   logic s1_take;
   logic s1_valid_ff;
   logic s1_valid_in;
   logic req_accept;

   assign out_free   = !rsp_valid || !rsp_stall;
   assign s1_take    = !s1_valid_ff || out_free;
   assign req_stall  = !s1_take;
   assign req_accept = req_valid && !req_stall;

   // Input register: hold the request word while the result stage is blocked.
   logic [CharWidth-1:0] s1_character_ff;
   logic                 s1_has_char_ff;
   logic                 s1_last_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_take) s1_valid_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_character_ff <= req_character;
         s1_has_char_ff  <= req_has_char;
         s1_last_ff      <= req_last;
      end
   end

   // ---------------------------------------------------------------------
   // Parse state and the per-character decision. The state advances only
   // when the word in the input register moves on, so a stall freezes it.
   // ---------------------------------------------------------------------
   hxb_state_type state_ff;
   hxb_state_type state_in;
   hxb_state_type state_step;
   hxb_res_type   step_res;
   logic          s1_advance;

   hxb_step u_step (
      .character    (s1_character_ff),
      .has_char     (s1_has_char_ff),
      .last         (s1_last_ff),
      .out_capacity (capacity_ff),
      .state_cur    (state_ff),
      .state_nxt    (state_step),
      .result       (step_res)
   );

   assign s1_advance = s1_valid_ff && out_free;

   always_comb begin
      state_in = state_ff;
      if (s1_advance) state_in = state_step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register. Words that produce nothing (plain separators, high
   // nibbles, empty markers) drop out here without taking a slot.
   // ---------------------------------------------------------------------
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   hxb_res_type rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) rsp_valid_in = s1_valid_ff && step_res.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload loads only when the slot is free, so a stalled word holds
   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_valid = rsp_ff.byte_valid;
   assign rsp_data_byte  = rsp_ff.data_byte;
   assign rsp_done_res   = rsp_ff.done_res;
   assign rsp_status     = rsp_ff.status;
   assign rsp_byte_count = rsp_ff.byte_count;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // a word mid-string exists only to carry a byte
   a_mid_carries_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_byte_valid)
      else $error("mid-string response without a byte");

   // status and count are zero except on the closing word
   a_mid_no_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> !rsp_status && (rsp_byte_count == '0))
      else $error("summary fields set on a mid-string response");

   // a byte on the closing word is counted in it
   a_done_byte_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_byte_valid |-> rsp_byte_count != '0)
      else $error("closing byte missing from the count");

   // never accept into a full input register that cannot drain
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !s1_valid_ff || out_free)
      else $error("input register overrun");

   // the parse state is clear at the start of every string
   a_clear_after_done: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_last_ff |=> state_ff == '0)
      else $error("parse state not cleared after end of string");

endmodule

`default_nettype wire

@@ dv/hex_text_to_bytes_tb.sv @@
// ----------------------------------------------------------------------------
// hex_text_to_bytes_tb
// Self-checking bench for the hex text parser. Strings are fed one character
// word at a time. A scoreboard class tracks the parse state, predicts every
// byte and done word, and matches them in order against the response port.
// Handshake idling and the capacity register are varied between phases.
// ----------------------------------------------------------------------------

module hex_text_to_bytes_tb;
   import hxb_pkg::*;

   localparam int   HalfPeriod  = 6;
   localparam int   ResetCycles = 7;
   localparam int   QuietLimit  = 2000;
   localparam int   DrainCycles = 4;
   localparam int   ItemsPerPhase = 280;
   localparam logic StatusOk        = 1'b0;
   localparam logic StatusMalformed = 1'b1;

   // one response word as seen on the rsp_ port
   typedef struct packed {
      logic                  byte_valid;
      logic [CharWidth-1:0]  data_byte;
      logic                  done_res;
      logic                  status;
      logic [CountWidth-1:0] byte_count;
   } result_word_type;

   // Parse state mirror plus the queue of response words still owed.
   class decoded_byte_ledger;
      logic [CountWidth-1:0] capacity;
      logic                  need_low;
      logic [NibWidth-1:0]   high_nibble;
      logic [CountWidth-1:0] produced;
      logic                  in_trailer;
      logic                  failed;
      result_word_type       awaited[$];
      int                    bad_words;

      function new();
         capacity  = CapacityReset;
         bad_words = 0;
         restart_string();
      endfunction

      function void restart_string();
         need_low    = 1'b0;
         high_nibble = '0;
         produced    = '0;
         in_trailer  = 1'b0;
         failed      = 1'b0;
      endfunction

      // -1 for anything that is not a hex digit
      function int nibble_of(logic [CharWidth-1:0] c);
         if (c >= ChZero && c <= ChNine) return int'(c - ChZero);
         if (c >= ChLowA && c <= ChLowF) return int'(c - ChLowA) + 10;
         if (c >= ChUpA && c <= ChUpF) return int'(c - ChUpA) + 10;
         return -1;
      endfunction

      function string describe(result_word_type w);
         return $sformatf("byte_valid=%0b data_byte=%h done_res=%0b status=%0b byte_count=%0d",
                          w.byte_valid, w.data_byte, w.done_res, w.status, w.byte_count);
      endfunction

      function void note_fault(string msg);
         bad_words++;
         if (bad_words <= 10) $display("%t: %s", $realtime, msg);
      endfunction

      // Advance the parse by one accepted request word.
      function void take_char(logic [CharWidth-1:0] ch, logic has, logic fin);
         int                   nib;
         logic                 is_sep;
         logic                 emit;
         logic [CharWidth-1:0] dbyte;
         result_word_type      w;
         emit  = 1'b0;
         dbyte = '0;
         if (has && !failed) begin
            nib    = nibble_of(ch);
            is_sep = (ch == ChSpace) || (ch == ChColon);
            if (in_trailer || produced >= capacity) begin
               in_trailer = 1'b1;
               if (!is_sep) failed = 1'b1;
            end else if (nib >= 0) begin
               if (need_low) begin
                  dbyte    = {high_nibble, nib[3:0]};
                  emit     = 1'b1;
                  produced = produced + 1'b1;
                  need_low = 1'b0;
               end else begin
                  high_nibble = nib[3:0];
                  need_low    = 1'b1;
               end
            end else if (is_sep) begin
               if (need_low) failed = 1'b1;
            end else begin
               failed = 1'b1;
            end
         end
         if (fin) begin
            // a lone nibble stands as a byte only if nothing came before
            if (!failed && need_low) begin
               if (produced == 0 && capacity != 0) begin
                  dbyte    = {4'h0, high_nibble};
                  emit     = 1'b1;
                  produced = CountWidth'(1);
                  need_low = 1'b0;
               end else begin
                  failed = 1'b1;
               end
            end
            w.byte_valid = emit;
            w.data_byte  = dbyte;
            w.done_res   = 1'b1;
            w.status     = failed ? StatusMalformed : StatusOk;
            w.byte_count = produced;
            awaited.push_back(w);
            restart_string();
         end else if (emit) begin
            w.byte_valid = 1'b1;
            w.data_byte  = dbyte;
            w.done_res   = 1'b0;
            w.status     = StatusOk;
            w.byte_count = '0;
            awaited.push_back(w);
         end
      endfunction

      function void match_word(result_word_type got);
         result_word_type want;
         if (awaited.size() == 0) begin
            note_fault({"unexpected response word: ", describe(got)});
            return;
         end
         want = awaited.pop_front();
         if (got.byte_valid !== want.byte_valid || got.data_byte !== want.data_byte ||
             got.done_res !== want.done_res || got.status !== want.status ||
             got.byte_count !== want.byte_count)
            note_fault({"response mismatch: expected ", describe(want),
                        " actual ", describe(got)});
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [CharWidth-1:0]    req_character = '0;
   logic                    req_has_char = 1'b0;
   logic                    req_last = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_byte_valid;
   logic [CharWidth-1:0]    rsp_data_byte;
   logic                    rsp_done_res;
   logic                    rsp_status;
   logic [CountWidth-1:0]   rsp_byte_count;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [AddrWidth-1:0]    paddr = '0;
   logic [CsrWidth-1:0]     pwdata = '0;
   logic [CsrWidth-1:0]     prdata;
   logic                    pready;

   decoded_byte_ledger ledger;
   result_word_type    seen_word;
   int                 req_idle_pct = 0;
   int                 rsp_idle_pct = 0;
   int                 items_sent = 0;
   int                 quiet_cycles = 0;

   hex_text_to_bytes dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_character  (req_character),
      .req_has_char   (req_has_char),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_done_res   (rsp_done_res),
      .rsp_status     (rsp_status),
      .rsp_byte_count (rsp_byte_count),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #HalfPeriod clock = ~clock;

   // Response side: check each word taken, then pick the stall for the next
   // cycle. Values read here are the ones from before this edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_word.byte_valid = rsp_byte_valid;
         seen_word.data_byte  = rsp_data_byte;
         seen_word.done_res   = rsp_done_res;
         seen_word.status     = rsp_status;
         seen_word.byte_count = rsp_byte_count;
         ledger.match_word(seen_word);
      end
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // Watchdog: drop the run if nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("FAIL hex_text_to_bytes");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request word, idling first at the sender's rate. Hold the
   // payload until the word is taken, then advance the prediction.
   task automatic send_word(input logic [CharWidth-1:0] ch, input logic has,
                            input logic fin);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_character <= ch;
      req_has_char  <= has;
      req_last      <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ledger.take_char(ch, has, fin);
      if (has || fin) items_sent++;
   endtask

   task automatic send_text(input string s, input bit close);
      for (int i = 0; i < s.len(); i++)
         send_word(s[i], 1'b1, close && (i == s.len() - 1));
   endtask

   // Drain every owed word, then give the pipeline time to empty behind
   // words that owe nothing.
   task automatic settle();
      req_valid <= 1'b0;
      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Write out_capacity (setup then access), then read it back.
   task automatic write_capacity(input logic [CountWidth-1:0] value);
      logic [CsrWidth-1:0] readback;
      settle();
      psel   <= 1'b1;
      pwrite <= 1'b1;
      paddr  <= AddrOutCapacity;
      pwdata <= {{(CsrWidth - CountWidth){1'b0}}, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      ledger.capacity = value;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      readback = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback[CountWidth-1:0] !== value)
         ledger.note_fault($sformatf("out_capacity readback: expected %0d actual %0d",
                                     value, readback[CountWidth-1:0]));
   endtask

   function automatic logic [CharWidth-1:0] random_digit();
      int v;
      v = $urandom_range(15);
      if (v < 10) return ChZero + CharWidth'(v);
      return ($urandom_range(1) ? ChLowA : ChUpA) + CharWidth'(v - 10);
   endfunction

   function automatic logic [CharWidth-1:0] random_sep();
      return $urandom_range(1) ? ChSpace : ChColon;
   endfunction

   // Mostly well-formed byte strings with random digits and separators;
   // a share carries a stray character or separator, or a dangling nibble.
   task automatic send_random_string();
      logic [CharWidth-1:0] text[$];
      int                   n_bytes;
      logic                 bare_end;
      n_bytes = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 5);
      if ($urandom_range(7) == 0) text.push_back(random_sep());
      for (int k = 0; k < n_bytes; k++) begin
         if (k != 0 && $urandom_range(1)) text.push_back(random_sep());
         text.push_back(random_digit());
         text.push_back(random_digit());
      end
      if ($urandom_range(7) == 0) text.push_back(random_digit());
      if ($urandom_range(5) == 0) text.push_back(random_sep());
      if ($urandom_range(99) < 15)
         text.insert($urandom_range(text.size()),
                     $urandom_range(1) ? CharWidth'($urandom_range(255)) : random_sep());
      bare_end = (text.size() == 0) || ($urandom_range(3) == 0);
      for (int k = 0; k < text.size(); k++) begin
         // sprinkle empty words, which the block must ignore
         if ($urandom_range(19) == 0) send_word(CharWidth'($urandom_range(255)), 1'b0, 1'b0);
         send_word(text[k], 1'b1, !bare_end && (k == text.size() - 1));
      end
      if (bare_end) send_word(CharWidth'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   initial begin
      int target;
      ledger = new();
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Directed: both cases, separators, empty word, end cases.
      write_capacity(CapacityReset);
      send_text("Af:09 ", 1'b0);
      send_word(CharWidth'($urandom_range(255)), 1'b0, 1'b0);
      send_text("Fa", 1'b1);
      send_word(CharWidth'($urandom_range(255)), 1'b0, 1'b1);   // bare end marker
      send_text("7", 1'b1);                                      // lone nibble
      send_text("123", 1'b1);                                    // dangling nibble
      send_word(8'h00, 1'b1, 1'b0);                              // NUL is invalid
      send_text("4", 1'b0);                                      // ignored after error
      send_word(CharWidth'($urandom_range(255)), 1'b0, 1'b1);
      send_text("5:", 1'b1);                                     // separator inside a byte
      send_word(8'hFF, 1'b1, 1'b1);
      send_word(8'h01, 1'b1, 1'b1);
      // capacity reached: separators pass, digits fail
      write_capacity(16'd1);
      send_text("12 3", 1'b1);
      // capacity lowered while a string is open
      write_capacity(CapacityReset);
      send_text("abcd", 1'b0);
      write_capacity(16'd1);
      send_text(":", 1'b1);
      // zero capacity: a lone nibble is an error, separators are fine
      write_capacity(16'd0);
      send_text("b", 1'b1);
      send_text(" ", 1'b1);

      // Random phases: sender-light idling, receiver-light, then none.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               write_capacity(CapacityReset);
               req_idle_pct = 17;
               rsp_idle_pct = 53;
            end
            1: begin
               write_capacity(CountWidth'($urandom_range(1, 5)));
               req_idle_pct = 53;
               rsp_idle_pct = 17;
            end
            default: begin
               write_capacity(CountWidth'($urandom_range(2, 40)));
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         target = items_sent + ItemsPerPhase;
         while (items_sent < target) send_random_string();
      end

      settle();
      repeat (DrainCycles) @(posedge clock);
      if (ledger.bad_words == 0 && ledger.awaited.size() == 0)
         $display("PASS hex_text_to_bytes");
      else
         $display("FAIL hex_text_to_bytes");
      $finish;
   end

endmodule
